FILE: rtl/kldiv_pkg.sv
package kldiv_pkg;

    // Default sizes for the top-level parameters.
    localparam int LOG_TABLE_ENTRIES_DEF = 256;
    localparam int ACC_WIDTH_DEF         = 48;

    // Field widths fixed by the interface.
    localparam int T_W        = 16;
    localparam int X_W        = 24;
    localparam int GRAD_W     = 17;
    localparam int LOSS_W     = 48;
    localparam int RECIP_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_AVERAGE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_RECIPROCAL = 2'd1;

    // Reset value of the reciprocal register (1.0 in Q1.16).
    localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd65536;

    // Arithmetic constants.
    localparam int LN2_Q16         = 45426;
    localparam int LN_SERIES_TERMS = 25;
    localparam logic [LOSS_W-1:0] LOSS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [LOSS_W-1:0] LOSS_MIN = 48'h8000_0000_0000;

    // One input word.
    typedef struct packed {
        logic [T_W-1:0]        target_prob;
        logic signed [X_W-1:0] input_logprob;
        logic                  last_element;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_value;
        logic signed [LOSS_W-1:0] loss_value;
        logic                     loss_valid;
    } t_out_word;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_TABLE,
        ST_INTERP,
        ST_PRODUCT,
        ST_ACCUM,
        ST_ABS,
        ST_MUL_FRAC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMBINE,
        ST_FINAL,
        ST_PUSH
    } t_kldiv_state;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic norm;
        logic lookup;
        logic interp;
        logic product;
        logic accum;
        logic absval;
        logic mul_frac;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic finish;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic avg;
        logic out_free;
    } t_dp_status;

    // Table entry ln(1 + z-derived ratio) in Q16 from the atanh series in Q32.
    // Only evaluated at elaboration to build the constant log table.
    function automatic logic [15:0] ln_series(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] full;
        z2   = (z * z) >> 32;
        term = z;
        sum  = 64'd0;
        for (int k = 0; k < LN_SERIES_TERMS; k++) begin
            sum  = sum + term / 64'(2 * k + 1);
            term = (term * z2) >> 32;
        end
        full = ((sum << 1) + 64'd32768) >> 16;
        return full[15:0];
    endfunction

endpackage

FILE: rtl/kldiv_ctrl.sv
module kldiv_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_ready,
    input  kldiv_pkg::t_dp_status i_status,
    output kldiv_pkg::t_dp_cmd    o_cmd
);

    kldiv_pkg::t_kldiv_state r_state;
    kldiv_pkg::t_kldiv_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kldiv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == kldiv_pkg::ST_IDLE);
        case (r_state)
            kldiv_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kldiv_pkg::ST_NORM;
                end
            end
            kldiv_pkg::ST_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = kldiv_pkg::ST_TABLE;
            end
            kldiv_pkg::ST_TABLE: begin
                o_cmd.lookup = 1'b1;
                n_state      = kldiv_pkg::ST_INTERP;
            end
            kldiv_pkg::ST_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = kldiv_pkg::ST_PRODUCT;
            end
            kldiv_pkg::ST_PRODUCT: begin
                o_cmd.product = 1'b1;
                n_state       = kldiv_pkg::ST_ACCUM;
            end
            kldiv_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                if (!i_status.last) begin
                    n_state = kldiv_pkg::ST_PUSH;
                end else if (i_status.avg) begin
                    n_state = kldiv_pkg::ST_ABS;
                end else begin
                    n_state = kldiv_pkg::ST_FINAL;
                end
            end
            kldiv_pkg::ST_ABS: begin
                o_cmd.absval = 1'b1;
                n_state      = kldiv_pkg::ST_MUL_FRAC;
            end
            kldiv_pkg::ST_MUL_FRAC: begin
                o_cmd.mul_frac = 1'b1;
                n_state        = kldiv_pkg::ST_MUL_LO;
            end
            kldiv_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = kldiv_pkg::ST_MUL_HI;
            end
            kldiv_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = kldiv_pkg::ST_COMBINE;
            end
            kldiv_pkg::ST_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state       = kldiv_pkg::ST_FINAL;
            end
            kldiv_pkg::ST_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = kldiv_pkg::ST_PUSH;
            end
            kldiv_pkg::ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = kldiv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kldiv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/kldiv_datapath.sv
module kldiv_datapath #(
    parameter int LOG_TABLE_ENTRIES = kldiv_pkg::LOG_TABLE_ENTRIES_DEF,
    parameter int ACC_WIDTH         = kldiv_pkg::ACC_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kldiv_pkg::t_dp_cmd                  i_cmd,
    output kldiv_pkg::t_dp_status               o_status,
    input  kldiv_pkg::t_in_word                 i_in_data,
    input  logic                                i_cfg_we,
    input  logic [kldiv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kldiv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output kldiv_pkg::t_out_word                o_out_data
);

    // Table index width, scaled-fraction width and loss-scaling split.
    localparam int IW  = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int S_W = 16 + IW;
    localparam int QW  = ACC_WIDTH - 16;
    localparam int QL  = (QW + 1) / 2;
    localparam int QH  = QW - QL;
    localparam int PW  = QW + 18;
    localparam int CW  = (PW > kldiv_pkg::LOSS_W + 1) ? PW : kldiv_pkg::LOSS_W + 1;
    localparam int SWL = (ACC_WIDTH > kldiv_pkg::LOSS_W) ? ACC_WIDTH : kldiv_pkg::LOSS_W;
    localparam logic signed [SWL-1:0] TOT_HI = SWL'($signed(kldiv_pkg::LOSS_MAX));
    localparam logic signed [SWL-1:0] TOT_LO = SWL'($signed(kldiv_pkg::LOSS_MIN));

    // Constant log table ln(1 + i/N) in Q16, built at elaboration.
    logic [15:0] w_ln_tab [LOG_TABLE_ENTRIES+1];

    for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] Z =
            (64'(gi) << 32) / 64'(2 * LOG_TABLE_ENTRIES + gi);
        localparam logic [15:0] LN_V = kldiv_pkg::ln_series(Z);
        assign w_ln_tab[gi] = LN_V;
    end

    // Configuration registers.
    logic                             r_avg;
    logic [kldiv_pkg::RECIP_W-1:0]    r_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= 1'b1;
            r_recip <= kldiv_pkg::RECIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kldiv_pkg::CFG_SIZE_AVERAGE:     r_avg   <= i_cfg_data[0];
                kldiv_pkg::CFG_COUNT_RECIPROCAL: r_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers for one word.
    logic [15:0]                r_t;
    logic signed [23:0]         r_x;
    logic                       r_last;
    logic [3:0]                 r_p;
    logic [15:0]                r_frac;
    logic [15:0]                r_lo;
    logic [15:0]                r_hi;
    logic [15:0]                r_w;
    logic signed [17:0]         r_lf;
    logic [19:0]                r_lnoff;
    logic signed [42:0]         r_prod;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [ACC_WIDTH-1:0] r_total;
    logic signed [16:0]         r_grad;
    logic [ACC_WIDTH-1:0]       r_mag;
    logic                       r_neg;
    logic [17:0]                r_pf;
    logic [QL+16:0]             r_plo;
    logic [QH+16:0]             r_phi;
    logic [PW-1:0]              r_pm;
    logic signed [47:0]         r_loss;
    logic                       r_out_valid;
    kldiv_pkg::t_out_word       r_out_data;

    // Normalize: msb position of t and the mantissa fraction.
    logic [3:0]  w_p;
    logic [31:0] w_shift;
    logic [15:0] w_frac;

    always_comb begin
        w_p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (r_t[i]) begin
                w_p = 4'(i);
            end
        end
    end

    assign w_shift = {16'b0, r_t} << (5'd16 - {1'b0, w_p});
    assign w_frac  = w_shift[15:0];

    // Table lookup: fraction scaled by the entry count gives index and weight.
    logic [S_W-1:0] w_s;
    logic [IW-1:0]  w_idx;
    logic [IW-1:0]  w_idx1;

    assign w_s    = S_W'(r_frac) * S_W'(LOG_TABLE_ENTRIES);
    assign w_idx  = w_s[S_W-1:16];
    assign w_idx1 = w_idx + IW'(1);

    // Interpolation between neighboring entries, plus the exponent offset.
    logic signed [33:0] w_diff;
    logic signed [33:0] w_ipr;
    logic signed [17:0] w_lf;
    logic [19:0]        w_lnoff;

    assign w_diff  = $signed({18'b0, r_hi}) - $signed({18'b0, r_lo});
    assign w_ipr   = w_diff * $signed({18'b0, r_w}) + 34'sd32768;
    assign w_lf    = $signed({2'b0, r_lo}) + 18'(w_ipr >>> 16);
    assign w_lnoff = 20'(5'd16 - {1'b0, r_p}) * 20'(kldiv_pkg::LN2_Q16);

    // Product t * (ln t - x).
    logic signed [25:0] w_lf26;
    logic signed [25:0] w_off26;
    logic signed [25:0] w_x26;
    logic signed [25:0] w_d;
    logic signed [42:0] w_prod;

    assign w_lf26  = 26'(r_lf);
    assign w_off26 = $signed({6'b0, r_lnoff});
    assign w_x26   = 26'(r_x);
    assign w_d     = w_lf26 - w_off26 - w_x26;
    assign w_prod  = $signed({27'b0, r_t}) * 43'(w_d);

    // Rounded term and saturating accumulate.
    logic signed [42:0]          w_rsum;
    logic signed [26:0]          w_term;
    logic signed [ACC_WIDTH:0]   w_acc_x;
    logic signed [ACC_WIDTH:0]   w_term_x;
    logic signed [ACC_WIDTH:0]   w_sum;
    logic signed [ACC_WIDTH-1:0] w_sat;
    logic signed [ACC_WIDTH-1:0] w_total;

    assign w_rsum   = r_prod + 43'sd32768;
    assign w_term   = w_rsum[42:16];
    assign w_acc_x  = (ACC_WIDTH+1)'(r_acc);
    assign w_term_x = (ACC_WIDTH+1)'(w_term);
    assign w_sum    = w_acc_x + w_term_x;

    always_comb begin
        if (w_sum[ACC_WIDTH] != w_sum[ACC_WIDTH-1]) begin
            w_sat = w_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_WIDTH-1:0];
        end
    end

    assign w_total = (r_t != 16'd0) ? w_sat : r_acc;

    // Gradient: negated magnitude, scaled when averaging and capped at 1.0.
    logic [33:0] w_gp;
    logic [17:0] w_m;
    logic [16:0] w_m_sat;
    logic [16:0] w_grad;

    assign w_gp    = 34'(r_t) * 34'(r_recip) + 34'd32768;
    assign w_m     = r_avg ? w_gp[33:16] : {2'b0, r_t};
    assign w_m_sat = (w_m > 18'd65536) ? 17'h10000 : w_m[16:0];
    assign w_grad  = (r_t == 16'd0) ? 17'd0 : (~w_m_sat + 17'd1);

    // Averaged loss: magnitude times reciprocal in three partial products.
    logic [ACC_WIDTH-1:0] w_mag;
    logic [33:0]          w_pf;
    logic [QL+16:0]       w_plo;
    logic [QH+16:0]       w_phi;
    logic [PW-1:0]        w_pm;

    assign w_mag = r_total[ACC_WIDTH-1] ? (~r_total + ACC_WIDTH'(1)) : r_total;
    assign w_pf  = 34'(r_mag[15:0]) * 34'(r_recip) + 34'd32768;
    assign w_plo = (QL+17)'(r_mag[16 +: QL]) * (QL+17)'(r_recip);
    assign w_phi = (QH+17)'(r_mag[16+QL +: QH]) * (QH+17)'(r_recip);
    assign w_pm  = PW'({r_phi, {QL{1'b0}}}) + PW'(r_plo) + PW'(r_pf);

    // Final loss with clamping to the 48-bit signed range.
    logic [CW-1:0]          w_pm_x;
    logic signed [SWL-1:0]  w_tot_x;
    logic [47:0]            w_loss;

    assign w_pm_x  = CW'(r_pm);
    assign w_tot_x = SWL'(r_total);

    always_comb begin
        if (r_avg) begin
            if (r_neg) begin
                w_loss = (w_pm_x > CW'(kldiv_pkg::LOSS_MIN)) ? kldiv_pkg::LOSS_MIN
                                                              : (~w_pm_x[47:0] + 48'd1);
            end else begin
                w_loss = (w_pm_x > CW'(kldiv_pkg::LOSS_MAX)) ? kldiv_pkg::LOSS_MAX
                                                              : w_pm_x[47:0];
            end
        end else if (w_tot_x > TOT_HI) begin
            w_loss = kldiv_pkg::LOSS_MAX;
        end else if (w_tot_x < TOT_LO) begin
            w_loss = kldiv_pkg::LOSS_MIN;
        end else begin
            w_loss = w_tot_x[47:0];
        end
    end

    // Payload registers, each loaded on its step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t    <= i_in_data.target_prob;
            r_x    <= i_in_data.input_logprob;
            r_last <= i_in_data.last_element;
        end
        if (i_cmd.norm) begin
            r_p    <= w_p;
            r_frac <= w_frac;
        end
        if (i_cmd.lookup) begin
            r_lo <= w_ln_tab[w_idx];
            r_hi <= w_ln_tab[w_idx1];
            r_w  <= w_s[15:0];
        end
        if (i_cmd.interp) begin
            r_lf    <= w_lf;
            r_lnoff <= w_lnoff;
        end
        if (i_cmd.product) begin
            r_prod <= w_prod;
        end
        if (i_cmd.accum) begin
            r_total <= w_total;
            r_grad  <= w_grad;
        end
        if (i_cmd.absval) begin
            r_mag <= w_mag;
            r_neg <= r_total[ACC_WIDTH-1];
        end
        if (i_cmd.mul_frac) begin
            r_pf <= w_pf[33:16];
        end
        if (i_cmd.mul_lo) begin
            r_plo <= w_plo;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_phi;
        end
        if (i_cmd.combine) begin
            r_pm <= w_pm;
        end
        if (i_cmd.finish) begin
            r_loss <= w_loss;
        end
    end

    // Loss accumulator, cleared by reset and after the last element.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= r_last ? '0 : w_total;
        end
    end

    // Output register: holds a finished word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data.grad_value <= r_grad;
            r_out_data.loss_value <= r_last ? r_loss : 48'sd0;
            r_out_data.loss_valid <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.last     = r_last;
    assign o_status.avg      = r_avg;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

FILE: rtl/kl_divergence_loss_and_gradient_core.sv
// The controller steps each word through normalize, table lookup, interpolate,
// multiply, accumulate and push on one shared datapath. A last element adds a
// final loss step before the push, and with averaging also absolute value,
// fraction, low and high partial products and combine before that. A new word
// is accepted only after the previous result word is pushed to the output.
// Reset (synchronous, active low) clears the accumulator and output valid, sets
// size_average to 1 and count_reciprocal to 1.0.
module kl_divergence_loss_and_gradient_core #(
    parameter int LOG_TABLE_ENTRIES = kldiv_pkg::LOG_TABLE_ENTRIES_DEF,
    parameter int ACC_WIDTH         = kldiv_pkg::ACC_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  kldiv_pkg::t_in_word               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output kldiv_pkg::t_out_word              o_out_data,
    input  logic                              i_cfg_we,
    input  logic [kldiv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kldiv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    kldiv_pkg::t_dp_cmd    w_cmd;
    kldiv_pkg::t_dp_status w_status;
    logic                  w_ready;

    // Controller.
    kldiv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_ready    (w_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    kldiv_datapath #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
        .ACC_WIDTH         (ACC_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !w_ready;

    // An accepted word keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accepted word");

    // A word that is not the last carries a zero loss.
    a_loss_zero_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.loss_valid) |-> (o_out_data.loss_value == 48'sd0))
        else $error("loss value set on a word that is not the last");

    // The gradient is never positive.
    a_grad_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.grad_value[16] || (o_out_data.grad_value == 17'sd0)))
        else $error("positive gradient");

    // A load command is only issued on an accepted input word.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in_valid && !o_in_stall))
        else $error("datapath loaded without an accepted word");

endmodule
